// ===== src/lrpd_pkg.sv =====
// ----------------------------------------------------------------------------
// lrpd_pkg: shared types and constants for the latching relay pulse driver
// Holds the item structs, the configuration register set, the phase
// encoding and the coil drive codes.
// ----------------------------------------------------------------------------
package lrpd_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENERGIZE_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_TICKS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WILD_ENABLE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WILD_PULSES    = 2'd3;
  localparam int unsigned CFG_DATA_W = 16;

  // Input command codes.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  // Coil drive codes: bit 1 drives the on coil, bit 0 the off coil.
  localparam logic [1:0] COIL_NONE = 2'b00;
  localparam logic [1:0] COIL_ON   = 2'b10;
  localparam logic [1:0] COIL_OFF  = 2'b01;

  localparam logic [15:0] TICKS_MAX = 16'hFFFF;

  // Sequencer phases.
  typedef enum logic [2:0] {
    PH_READY    = 3'd0,
    PH_ENERGIZE = 3'd1,
    PH_WILD_OFF = 3'd2,
    PH_WILD_ON  = 3'd3,
    PH_PAUSE    = 3'd4
  } phase_t;

  // Input item.
  typedef struct packed {
    logic command;
    logic value;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic coil_on;
    logic coil_off;
    logic busy_res;
    logic relay_value;
  } out_item_t;

  // Configuration register set.
  typedef struct packed {
    logic [15:0] energize_ticks;
    logic [15:0] pause_ticks;
    logic        wild_enable;
    logic [7:0]  wild_pulses;
  } cfg_regs_t;

endpackage

// ===== src/latching_relay_pulse_driver.sv =====
// ----------------------------------------------------------------------------
// latching_relay_pulse_driver: bistable relay coil sequencer
//
//   Channel  Direction  Handshake           Payload
//   in_      input      in_valid/in_ready   lrpd_pkg::in_item_t  (tick or set)
//   out_     output     out_valid/out_ready lrpd_pkg::out_item_t (coil state)
//   cfg_     input      cfg_we              cfg_idx, cfg_wdata
//
// One item is taken per cycle unless the output stalls; each gives one result,
// passing through the input register, then the result register.
// The sequencer state advances when an item leaves the input register, so a
// single compare and counter update set the per-item cost.
// Reset is synchronous; it clears the sequencer and all configuration.
// A stalled result holds its item; the input register still takes one more.
// ----------------------------------------------------------------------------
module latching_relay_pulse_driver (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lrpd_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lrpd_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [lrpd_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [lrpd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  lrpd_pkg::cfg_regs_t  cfg_regs;
  lrpd_pkg::in_item_t   s1_data_r;
  logic                 s1_valid_r, s1_valid_nxt;
  logic                 out_valid_r, out_valid_nxt;
  lrpd_pkg::out_item_t  out_data_r;
  lrpd_pkg::out_item_t  result;
  logic                 s1_adv;

  lrpd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg_regs  (cfg_regs)
  );

  lrpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (s1_adv),
    .item     (s1_data_r),
    .cfg_regs (cfg_regs),
    .result   (result)
  );

  // The input register moves on whenever the result register is free.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt  = (in_valid && in_ready) || (s1_valid_r && !s1_adv);
    out_valid_nxt = s1_adv || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A ready result never shows a driven coil.
  a_ready_coils_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.busy_res |-> !out_data_r.coil_on && !out_data_r.coil_off)
    else $error("ready result with a coil driven");

  // A set always yields a busy result carrying the commanded value.
  a_set_busy: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_data_r.command |=>
      out_data_r.busy_res && (out_data_r.relay_value == $past(s1_data_r.value)))
    else $error("set did not give a busy result with its value");

  // Input is held off only while both stages are full and the output stalls.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled without a full pipeline");

endmodule

// ===== src/lrpd_cfg.sv =====
// ----------------------------------------------------------------------------
// lrpd_cfg: configuration registers
// Decodes the write port and holds the four timing and mode registers.
// ----------------------------------------------------------------------------
module lrpd_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lrpd_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [lrpd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output lrpd_pkg::cfg_regs_t                 cfg_regs
);

  lrpd_pkg::cfg_regs_t regs_r;
  lrpd_pkg::cfg_regs_t regs_nxt;

  // Register write decode.
  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        lrpd_pkg::CFG_ENERGIZE_TICKS: regs_nxt.energize_ticks = cfg_wdata;
        lrpd_pkg::CFG_PAUSE_TICKS:    regs_nxt.pause_ticks    = cfg_wdata;
        lrpd_pkg::CFG_WILD_ENABLE:    regs_nxt.wild_enable    = cfg_wdata[0];
        lrpd_pkg::CFG_WILD_PULSES:    regs_nxt.wild_pulses    = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign cfg_regs = regs_r;

endmodule

// ===== src/lrpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrpd_ctrl: pulse sequencer
// Holds the phase, timer and coil state and advances them by one item
// whenever step is high. The result reflects the state after the item.
// ----------------------------------------------------------------------------
module lrpd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  lrpd_pkg::in_item_t   item,
  input  lrpd_pkg::cfg_regs_t  cfg_regs,
  output lrpd_pkg::out_item_t  result
);

  lrpd_pkg::phase_t phase_r, phase_nxt;
  logic [15:0]      elapsed_r, elapsed_nxt;
  logic [15:0]      interval_r, interval_nxt;
  logic [7:0]       pulse_r, pulse_nxt;
  logic             wanted_r, wanted_nxt;
  logic [1:0]       coil_r, coil_nxt;
  logic [15:0]      elapsed_inc;
  logic             expired;

  // Saturating tick count and expiry compare.
  assign elapsed_inc = (elapsed_r == lrpd_pkg::TICKS_MAX) ? elapsed_r
                                                          : elapsed_r + 16'd1;
  assign expired     = (elapsed_inc >= interval_r);

  // Next state.
  always_comb begin
    phase_nxt    = phase_r;
    elapsed_nxt  = elapsed_r;
    interval_nxt = interval_r;
    pulse_nxt    = pulse_r;
    wanted_nxt   = wanted_r;
    coil_nxt     = coil_r;
    if (step) begin
      if (item.command == lrpd_pkg::CMD_SET) begin
        // A set restarts the sequence and only adds the coil it needs.
        wanted_nxt   = item.value;
        coil_nxt     = coil_r | (item.value ? lrpd_pkg::COIL_ON : lrpd_pkg::COIL_OFF);
        interval_nxt = cfg_regs.energize_ticks;
        elapsed_nxt  = '0;
        if (cfg_regs.wild_enable && item.value) begin
          pulse_nxt = '0;
          phase_nxt = lrpd_pkg::PH_WILD_OFF;
        end else begin
          phase_nxt = lrpd_pkg::PH_ENERGIZE;
        end
      end else begin
        unique case (phase_r)
          lrpd_pkg::PH_ENERGIZE: begin
            elapsed_nxt = elapsed_inc;
            if (expired) begin
              coil_nxt     = lrpd_pkg::COIL_NONE;
              interval_nxt = cfg_regs.pause_ticks;
              elapsed_nxt  = '0;
              phase_nxt    = lrpd_pkg::PH_PAUSE;
            end
          end
          lrpd_pkg::PH_WILD_OFF: begin
            elapsed_nxt = elapsed_inc;
            if (expired) begin
              coil_nxt = wanted_r ? lrpd_pkg::COIL_OFF : lrpd_pkg::COIL_ON;
              if (pulse_r < cfg_regs.wild_pulses) begin
                phase_nxt   = lrpd_pkg::PH_WILD_ON;
                elapsed_nxt = '0;
              end else begin
                coil_nxt     = lrpd_pkg::COIL_NONE;
                interval_nxt = cfg_regs.pause_ticks;
                elapsed_nxt  = '0;
                phase_nxt    = lrpd_pkg::PH_PAUSE;
              end
            end
          end
          lrpd_pkg::PH_WILD_ON: begin
            elapsed_nxt = elapsed_inc;
            if (expired) begin
              pulse_nxt   = pulse_r + 8'd1;
              coil_nxt    = wanted_r ? lrpd_pkg::COIL_ON : lrpd_pkg::COIL_OFF;
              elapsed_nxt = '0;
              phase_nxt   = lrpd_pkg::PH_WILD_OFF;
            end
          end
          lrpd_pkg::PH_PAUSE: begin
            elapsed_nxt = elapsed_inc;
            if (expired) begin
              phase_nxt = lrpd_pkg::PH_READY;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Result fields from the updated state.
  always_comb begin
    result.coil_on     = coil_nxt[1];
    result.coil_off    = coil_nxt[0];
    result.relay_value = wanted_nxt;
    unique case (phase_nxt) inside
      lrpd_pkg::PH_ENERGIZE, lrpd_pkg::PH_WILD_OFF,
      lrpd_pkg::PH_WILD_ON, lrpd_pkg::PH_PAUSE: result.busy_res = 1'b1;
      default:                                   result.busy_res = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= lrpd_pkg::PH_READY;
      elapsed_r  <= '0;
      interval_r <= '0;
      pulse_r    <= '0;
      wanted_r   <= 1'b0;
      coil_r     <= lrpd_pkg::COIL_NONE;
    end else begin
      phase_r    <= phase_nxt;
      elapsed_r  <= elapsed_nxt;
      interval_r <= interval_nxt;
      pulse_r    <= pulse_nxt;
      wanted_r   <= wanted_nxt;
      coil_r     <= coil_nxt;
    end
  end

endmodule

// ===== verif/lrpd_relay_checker.sv =====
// ----------------------------------------------------------------------------
// lrpd_relay_checker: result checker for the latching relay pulse driver
// Watches the configuration port and both item channels. It keeps its own
// copy of the coil sequencer, works out the coil state that each accepted
// item should produce, and compares every accepted result with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module lrpd_relay_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  lrpd_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  lrpd_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [lrpd_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lrpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned                     fail_count,
  output int unsigned                     pending_count
);

  // Shadow copy of the configuration and the sequencer state.
  lrpd_pkg::cfg_regs_t regs;
  lrpd_pkg::phase_t    rly_phase;
  logic [15:0]         tmr_elapsed;
  logic [15:0]         tmr_interval;
  logic [7:0]          pulse_cnt;
  logic                want_val;
  logic [1:0]          coil_drv;

  // Predicted coil states, oldest first.
  lrpd_pkg::out_item_t coil_state_q[$];
  int unsigned         errs = 0;

  // Drop both coils and start the after pause.
  task automatic start_pause();
    coil_drv     = lrpd_pkg::COIL_NONE;
    tmr_interval = regs.pause_ticks;
    tmr_elapsed  = '0;
    rly_phase    = lrpd_pkg::PH_PAUSE;
  endtask

  // Advance the sequencer by one item and return the coil state it leaves.
  task automatic step_relay(input lrpd_pkg::in_item_t it, output lrpd_pkg::out_item_t res);
    logic expired;
    expired = 1'b0;
    if (it.command == lrpd_pkg::CMD_SET) begin
      // A set only adds its own coil; a reversing set can drive both.
      want_val = it.value;
      coil_drv = coil_drv | (it.value ? lrpd_pkg::COIL_ON : lrpd_pkg::COIL_OFF);
      if (regs.wild_enable && it.value) begin
        pulse_cnt = '0;
        rly_phase = lrpd_pkg::PH_WILD_OFF;
      end else begin
        rly_phase = lrpd_pkg::PH_ENERGIZE;
      end
      tmr_interval = regs.energize_ticks;
      tmr_elapsed  = '0;
    end else begin
      // The timer only runs outside the ready phase; the count saturates.
      if (rly_phase != lrpd_pkg::PH_READY) begin
        if (tmr_elapsed != lrpd_pkg::TICKS_MAX) tmr_elapsed = tmr_elapsed + 16'd1;
        expired = (tmr_elapsed >= tmr_interval);
      end
      case (rly_phase)
        lrpd_pkg::PH_ENERGIZE: begin
          if (expired) start_pause();
        end
        lrpd_pkg::PH_WILD_OFF: begin
          if (expired) begin
            coil_drv = want_val ? lrpd_pkg::COIL_OFF : lrpd_pkg::COIL_ON;
            if (pulse_cnt < regs.wild_pulses) begin
              rly_phase   = lrpd_pkg::PH_WILD_ON;
              tmr_elapsed = '0;
            end else begin
              start_pause();
            end
          end
        end
        lrpd_pkg::PH_WILD_ON: begin
          if (expired) begin
            pulse_cnt   = pulse_cnt + 8'd1;
            coil_drv    = want_val ? lrpd_pkg::COIL_ON : lrpd_pkg::COIL_OFF;
            tmr_elapsed = '0;
            rly_phase   = lrpd_pkg::PH_WILD_OFF;
          end
        end
        lrpd_pkg::PH_PAUSE: begin
          if (expired) rly_phase = lrpd_pkg::PH_READY;
        end
        default: begin
        end
      endcase
    end
    res.coil_on     = coil_drv[1];
    res.coil_off    = coil_drv[0];
    res.busy_res    = (rly_phase != lrpd_pkg::PH_READY);
    res.relay_value = want_val;
  endtask

  // Track configuration writes, compare results, then predict new items.
  always @(posedge clk) begin : watch
    lrpd_pkg::out_item_t want;
    lrpd_pkg::out_item_t res;
    if (!rst_n) begin
      regs         = '0;
      rly_phase    = lrpd_pkg::PH_READY;
      tmr_elapsed  = '0;
      tmr_interval = '0;
      pulse_cnt    = '0;
      want_val     = 1'b0;
      coil_drv     = lrpd_pkg::COIL_NONE;
      coil_state_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          lrpd_pkg::CFG_ENERGIZE_TICKS: regs.energize_ticks = cfg_wdata;
          lrpd_pkg::CFG_PAUSE_TICKS:    regs.pause_ticks    = cfg_wdata;
          lrpd_pkg::CFG_WILD_ENABLE:    regs.wild_enable    = cfg_wdata[0];
          lrpd_pkg::CFG_WILD_PULSES:    regs.wild_pulses    = cfg_wdata[7:0];
          default: begin
          end
        endcase
      end

      if (out_valid && out_ready) begin
        if (coil_state_q.size() == 0) begin
          if (errs < 10)
            $display("%0t: result on=%b off=%b busy=%b val=%b with no item outstanding",
                     $time, out_data.coil_on, out_data.coil_off, out_data.busy_res,
                     out_data.relay_value);
          errs++;
        end else begin
          want = coil_state_q.pop_front();
          if (out_data.coil_on !== want.coil_on || out_data.coil_off !== want.coil_off ||
              out_data.busy_res !== want.busy_res ||
              out_data.relay_value !== want.relay_value) begin
            if (errs < 10)
              $display("%0t: exp on=%b off=%b busy=%b val=%b got on=%b off=%b busy=%b val=%b",
                       $time, want.coil_on, want.coil_off, want.busy_res, want.relay_value,
                       out_data.coil_on, out_data.coil_off, out_data.busy_res,
                       out_data.relay_value);
            errs++;
          end
        end
      end

      if (in_valid && in_ready) begin
        step_relay(in_data, res);
        coil_state_q = {coil_state_q, res};
      end
    end
    fail_count    <= errs;
    pending_count <= coil_state_q.size();
  end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: top level for the latching relay pulse driver
// Drives ticks and set commands through the input channel under several
// register settings and idling patterns, including a full-scale energize
// interval and a full wild pulse train. A checker beside the block predicts
// and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned N_PHASES     = 8;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  lrpd_pkg::in_item_t              in_data   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  lrpd_pkg::out_item_t             out_data;
  logic                            cfg_we    = 1'b0;
  logic [lrpd_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [lrpd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned cycle_cnt    = 0;
  int unsigned send_pct     = 0;
  int unsigned stall_pct    = 0;
  int unsigned items_sent   = 0;
  int unsigned sets_sent    = 0;
  int unsigned settings_cnt = 0;

  always #1 clk = ~clk;

  latching_relay_pulse_driver i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  lrpd_relay_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Receiver side: stall at random at the current rate.
  always @(posedge clk) begin
    if (stall_pct == 0) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAILURE");
      $finish;
    end
  end

  // Idling patterns: none, sender idle, receiver stalling, both.
  task automatic set_idling(input int unsigned mode);
    case (mode)
      1: begin send_pct = 79; stall_pct <= 0; end
      2: begin send_pct = 0;  stall_pct <= 79; end
      3: begin send_pct = 25; stall_pct <= 25; end
      default: begin send_pct = 0; stall_pct <= 0; end
    endcase
  endtask

  // Write all four registers on consecutive cycles.
  task automatic load_config(input logic [15:0] energize, input logic [15:0] pause,
                             input logic wild, input logic [7:0] pulses);
    cfg_we    <= 1'b1;
    cfg_idx   <= lrpd_pkg::CFG_ENERGIZE_TICKS;
    cfg_wdata <= energize;
    @(posedge clk);
    cfg_idx   <= lrpd_pkg::CFG_PAUSE_TICKS;
    cfg_wdata <= pause;
    @(posedge clk);
    cfg_idx   <= lrpd_pkg::CFG_WILD_ENABLE;
    cfg_wdata <= {15'd0, wild};
    @(posedge clk);
    cfg_idx   <= lrpd_pkg::CFG_WILD_PULSES;
    cfg_wdata <= {8'd0, pulses};
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings_cnt++;
  endtask

  // Offer one item, with an optional idle gap first, and wait for acceptance.
  task automatic send_item(input logic cmd, input logic val);
    lrpd_pkg::in_item_t it;
    it.command = cmd;
    it.value   = val;
    if (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (cmd == lrpd_pkg::CMD_SET) sets_sent++;
  endtask

  // Stop sending and wait until every result has come back.
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [15:0] energize;
    logic [15:0] pause;
    logic        wild;
    logic [7:0]  pulses;
    int unsigned n_items;
    int unsigned set_pct;
    logic        cmd;
    logic        val;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, zero intervals, tick while ready.
    set_idling(0);
    send_item(lrpd_pkg::CMD_TICK, 1'b0);
    send_item(lrpd_pkg::CMD_SET, 1'b0);
    send_item(lrpd_pkg::CMD_TICK, 1'b1);
    send_item(lrpd_pkg::CMD_TICK, 1'b0);
    send_item(lrpd_pkg::CMD_SET, 1'b1);
    send_item(lrpd_pkg::CMD_TICK, 1'b0);
    send_item(lrpd_pkg::CMD_TICK, 1'b0);
    wait_drain();

    // Directed: short wild train, then a reversing set in the middle of it.
    load_config(16'd2, 16'd1, 1'b1, 8'd2);
    send_item(lrpd_pkg::CMD_SET, 1'b1);
    repeat (6) send_item(lrpd_pkg::CMD_TICK, 1'b0);
    send_item(lrpd_pkg::CMD_SET, 1'b0);
    repeat (4) send_item(lrpd_pkg::CMD_TICK, 1'b0);
    wait_drain();

    // Directed: wild off, set 0 then an immediate set 1 drives both coils.
    load_config(16'd1, 16'd1, 1'b0, 8'd1);
    send_item(lrpd_pkg::CMD_SET, 1'b0);
    send_item(lrpd_pkg::CMD_SET, 1'b1);
    repeat (4) send_item(lrpd_pkg::CMD_TICK, 1'b0);
    wait_drain();

    // Directed: a full-scale energize interval keeps the coil driven.
    load_config(lrpd_pkg::TICKS_MAX, 16'd0, 1'b0, 8'd0);
    send_item(lrpd_pkg::CMD_SET, 1'b0);
    repeat (20) send_item(lrpd_pkg::CMD_TICK, 1'b0);
    wait_drain();

    // Random phases, each under its own settings and idling pattern.
    for (int unsigned ph = 0; ph < N_PHASES; ph++) begin
      energize = 16'($urandom_range(0, 5));
      pause    = 16'($urandom_range(0, 5));
      wild     = 1'($urandom_range(1));
      pulses   = 8'($urandom_range(0, 3));
      n_items  = 140;
      set_pct  = 18;
      if (ph == 5) begin
        // Longest wild train with zero intervals: one set, then ticks only.
        energize = 16'd0;
        pause    = 16'd0;
        wild     = 1'b1;
        pulses   = 8'hFF;
        n_items  = 560;
        set_pct  = 0;
      end else if (ph == 6) begin
        energize = lrpd_pkg::TICKS_MAX;
        pause    = lrpd_pkg::TICKS_MAX;
        pulses   = 8'hFF;
        n_items  = 40;
        set_pct  = 30;
      end
      load_config(energize, pause, wild, pulses);
      set_idling(ph % 4);
      for (int unsigned n = 0; n < n_items; n++) begin
        // Hold off once until the block has returned every result.
        if (ph == 2 && n == 80) wait_drain();
        cmd = (n == 0 || $urandom_range(99) < set_pct) ? lrpd_pkg::CMD_SET
                                                       : lrpd_pkg::CMD_TICK;
        val = (ph == 5) ? 1'b1 : 1'($urandom_range(1));
        send_item(cmd, val);
      end
      wait_drain();
    end

    $display("Run covered %0d items, %0d of them set commands, over %0d register settings,",
             items_sent, sets_sent, settings_cnt);
    $display("including a full-scale energize interval and a 255-pair alternating train.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
